// ===== hw/rtl/aprc_pkg.sv =====
// ----------------------------------------------------------------------------
// aprc_pkg
// Shared types and codes of the rectangle pair collision resolver.
// ----------------------------------------------------------------------------
package aprc_pkg;

  localparam int MAP_BITS  = 15;
  localparam int KIND_BITS = 2;
  localparam int IDX_BITS  = 3;
  localparam int SIDE_BITS = 3;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [KIND_BITS-1:0] KIND_POS  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_PAIR = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd2;

  localparam logic [SIDE_BITS-1:0] SIDE_LEFT   = 3'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_RIGHT  = 3'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_ABOVE  = 3'd2;
  localparam logic [SIDE_BITS-1:0] SIDE_BELOW  = 3'd3;
  localparam logic [SIDE_BITS-1:0] SIDE_CORNER = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 1'd1;

  localparam logic [MAP_BITS-1:0] MAP_RESET = 15'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_LD_A,
    ST_CMP,
    ST_ISECT,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/aprc_in_if.sv =====
// ----------------------------------------------------------------------------
// aprc_in_if
// Entity channel: one rectangle per transaction.
// ----------------------------------------------------------------------------
interface aprc_in_if #(
  parameter int COORD_BITS = 16,
  parameter int SIZE_BITS  = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_position;
  logic signed [COORD_BITS-1:0] y_position;
  logic        [SIZE_BITS-1:0]  box_width;
  logic        [SIZE_BITS-1:0]  box_height;
  logic                         final_entity;

  modport source (
    output valid, x_position, y_position, box_width, box_height, final_entity,
    input  ready
  );
  modport sink (
    input  valid, x_position, y_position, box_width, box_height, final_entity,
    output ready
  );
endinterface

// ===== hw/rtl/aprc_out_if.sv =====
// ----------------------------------------------------------------------------
// aprc_out_if
// Result channel: a clamped position, pair or no-pair result per transaction.
// ----------------------------------------------------------------------------
interface aprc_out_if
  import aprc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int SIZE_BITS  = 12
);
  logic                         valid;
  logic                         ready;
  logic        [KIND_BITS-1:0]  result_kind;
  logic        [IDX_BITS-1:0]   first_index;
  logic        [IDX_BITS-1:0]   second_index;
  logic signed [COORD_BITS-1:0] clamped_x;
  logic signed [COORD_BITS-1:0] clamped_y;
  logic        [SIDE_BITS-1:0]  contact_side;
  logic signed [SIZE_BITS:0]    push_a_x;
  logic signed [SIZE_BITS:0]    push_a_y;
  logic signed [SIZE_BITS:0]    push_b_x;
  logic signed [SIZE_BITS:0]    push_b_y;
  logic                         run_end;

  modport source (
    output valid, result_kind, first_index, second_index, clamped_x, clamped_y,
           contact_side, push_a_x, push_a_y, push_b_x, push_b_y, run_end,
    input  ready
  );
  modport sink (
    input  valid, result_kind, first_index, second_index, clamped_x, clamped_y,
           contact_side, push_a_x, push_a_y, push_b_x, push_b_y, run_end,
    output ready
  );
endinterface

// ===== hw/rtl/aprc_ram.sv =====
// ----------------------------------------------------------------------------
// aprc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/aabb_pair_collision_resolver.sv =====
// ----------------------------------------------------------------------------
// aabb_pair_collision_resolver
// Clamps entity rectangles to the map, stores them, and on the last entity
// of a frame tests every stored pair for overlap and reports push vectors.
//
//   Channel   Dir  Handshake       Contents
//   in_ch     in   valid/ready     x, y, width, height, final flag
//   out_ch    out  valid/ready     kind, indices, position, side, pushes
//   cfg_*     in   write enable    map width (0), map height (1)
//
// A transaction is taken when the output register is free; while the store
// has room, it yields its clamped position in the next cycle. The pair scan
// reads the store through one RAM read port: RD_A, LD_A per first entity;
// CMP, ISECT, EMIT per pair; DONE closes the frame. Reset is synchronous and
// leaves the store contents undefined. Input is not taken during a scan.
// ----------------------------------------------------------------------------
module aabb_pair_collision_resolver
  import aprc_pkg::*;
#(
  parameter int MAX_ENTITIES = 8,
  parameter int COORD_BITS   = 16,
  parameter int SIZE_BITS    = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  aprc_in_if.sink                 in_ch,
  aprc_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [MAP_BITS-1:0]     cfg_data
);

  localparam int IW   = $clog2(MAX_ENTITIES);
  localparam int CNTW = $clog2(MAX_ENTITIES + 1);
  localparam int SW   = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int EW0  = (COORD_BITS > SIZE_BITS + 1) ? COORD_BITS : SIZE_BITS + 1;
  localparam int EW   = EW0 + 1;
  localparam int CW   = ((EW0 > MAP_BITS + 1) ? EW0 : MAP_BITS + 1) + 1;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_ENTITIES);
  localparam logic [CNTW-1:0] TWO     = CNTW'(2);

  function automatic logic signed [COORD_BITS-1:0] clamp_axis(
    input logic signed [COORD_BITS-1:0] p,
    input logic        [SIZE_BITS-1:0]  s,
    input logic        [MAP_BITS-1:0]   lim
  );
    logic signed [CW-1:0] pe;
    logic signed [CW-1:0] se;
    logic signed [CW-1:0] le;
    logic signed [CW-1:0] r;
    pe = CW'(p);
    se = CW'({1'b0, s});
    le = CW'({1'b0, lim});
    if (pe + se > le) begin
      r = le - se;
    end else if (pe < 0) begin
      r = '0;
    end else begin
      r = pe;
    end
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [EW-1:0] edge_end(
    input logic signed [COORD_BITS-1:0] p,
    input logic        [SIZE_BITS-1:0]  s
  );
    return EW'(p) + EW'({1'b0, s});
  endfunction

  state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [MAP_BITS-1:0] map_w_r, map_h_r;

  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic        [SIZE_BITS-1:0]  aw_r, ah_r, bw_r, bh_r;
  logic signed [EW-1:0]         axe_r, aye_r, bxe_r, bye_r;

  logic                  hit_r, left_r, right_r, above_r, below_r;
  logic [SIZE_BITS-1:0]  iw_r, ih_r;

  logic                         pend_v_r, pend_v_nxt;
  logic [IDX_BITS-1:0]          pend_a_r, pend_b_r;
  logic [SIDE_BITS-1:0]         pend_side_r;
  logic signed [SIZE_BITS:0]    pend_pax_r, pend_pay_r, pend_pbx_r, pend_pby_r;

  logic                         out_v_r, out_v_nxt;
  logic                         out_load;
  logic [KIND_BITS-1:0]         o_kind_r, o_kind_nxt;
  logic [IDX_BITS-1:0]          o_first_r, o_first_nxt, o_second_r, o_second_nxt;
  logic signed [COORD_BITS-1:0] o_cx_r, o_cx_nxt, o_cy_r, o_cy_nxt;
  logic [SIDE_BITS-1:0]         o_side_r, o_side_nxt;
  logic signed [SIZE_BITS:0]    o_pax_r, o_pax_nxt, o_pay_r, o_pay_nxt;
  logic signed [SIZE_BITS:0]    o_pbx_r, o_pbx_nxt, o_pby_r, o_pby_nxt;
  logic                         o_end_r, o_end_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  logic signed [COORD_BITS-1:0] cx, cy, rd_x, rd_y;
  logic        [SIZE_BITS-1:0]  rd_w, rd_h;
  logic signed [COORD_BITS-1:0] ix, iy;
  logic signed [EW-1:0]         xe, ye;
  logic signed [EW:0]           iwf, ihf;
  logic                         in_acc, out_free, store_ok, pair_go;
  logic [CNTW-1:0]              n_load, j_p1, i_p2;
  logic                         ab, lr, tall;
  logic signed [SIZE_BITS:0]    piw, pih;
  logic [SIDE_BITS-1:0]         new_side;
  logic signed [SIZE_BITS:0]    new_pax, new_pay, new_pbx, new_pby;

  aprc_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ENTITIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {rd_x, rd_y, rd_w, rd_h} = ram_rdata;

  assign out_free = !out_v_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign store_ok = cnt_r < MAX_CNT;

  assign cx = clamp_axis(in_ch.x_position, in_ch.box_width, map_w_r);
  assign cy = clamp_axis(in_ch.y_position, in_ch.box_height, map_h_r);
  assign ram_wdata = {cx, cy, in_ch.box_width, in_ch.box_height};
  assign ram_we    = in_acc && store_ok;
  assign n_load    = store_ok ? CNTW'(cnt_r + 1'b1) : cnt_r;

  assign j_p1 = CNTW'(CNTW'(j_r) + 1'b1);
  assign i_p2 = CNTW'(CNTW'(i_r) + TWO);

  // Intersection of the latched pair.
  assign ix  = (ax_r >= bx_r) ? ax_r : bx_r;
  assign iy  = (ay_r >= by_r) ? ay_r : by_r;
  assign xe  = (axe_r <= bxe_r) ? axe_r : bxe_r;
  assign ye  = (aye_r <= bye_r) ? aye_r : bye_r;
  assign iwf = (EW+1)'(xe) - (EW+1)'(ix);
  assign ihf = (EW+1)'(ye) - (EW+1)'(iy);

  // Contact side and pushes.
  assign ab   = above_r || below_r;
  assign lr   = left_r || right_r;
  assign tall = ih_r > iw_r;
  assign piw  = {1'b0, iw_r};
  assign pih  = {1'b0, ih_r};

  always_comb begin
    new_side = SIDE_CORNER;
    new_pax  = '0;
    new_pay  = '0;
    new_pbx  = '0;
    new_pby  = '0;
    if (left_r && (!ab || tall)) begin
      new_side = SIDE_LEFT;
      new_pax  = -piw;
      new_pbx  = piw;
    end else if (right_r && (!ab || tall)) begin
      new_side = SIDE_RIGHT;
      new_pax  = piw;
      new_pbx  = -piw;
    end else if (above_r && (!lr || !tall)) begin
      new_side = SIDE_ABOVE;
      new_pay  = -pih;
      new_pby  = pih;
    end else if (below_r && (!lr || !tall)) begin
      new_side = SIDE_BELOW;
      new_pay  = pih;
      new_pby  = -pih;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    pend_v_nxt   = pend_v_r;
    pair_go      = 1'b0;
    in_ch.ready  = 1'b0;
    ram_raddr    = i_r;
    out_load     = 1'b0;
    out_v_nxt    = out_v_r && !out_ch.ready;
    o_kind_nxt   = KIND_POS;
    o_first_nxt  = '0;
    o_second_nxt = '0;
    o_cx_nxt     = '0;
    o_cy_nxt     = '0;
    o_side_nxt   = '0;
    o_pax_nxt    = '0;
    o_pay_nxt    = '0;
    o_pbx_nxt    = '0;
    o_pby_nxt    = '0;
    o_end_nxt    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = out_free;
        if (in_acc) begin
          cnt_nxt = n_load;
          if (store_ok) begin
            out_load    = 1'b1;
            o_first_nxt = IDX_BITS'(cnt_r);
            o_cx_nxt    = cx;
            o_cy_nxt    = cy;
            o_end_nxt   = !in_ch.final_entity;
          end
          if (in_ch.final_entity) begin
            i_nxt      = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = (n_load < TWO) ? ST_DONE : ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        ram_raddr = i_r;
        state_nxt = ST_LD_A;
      end
      ST_LD_A: begin
        ram_raddr = i_r + 1'b1;
        j_nxt     = i_r + 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_ISECT;
      end
      ST_ISECT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        ram_raddr = j_r + 1'b1;
        if (hit_r && pend_v_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            o_kind_nxt   = KIND_PAIR;
            o_first_nxt  = pend_a_r;
            o_second_nxt = pend_b_r;
            o_side_nxt   = pend_side_r;
            o_pax_nxt    = pend_pax_r;
            o_pay_nxt    = pend_pay_r;
            o_pbx_nxt    = pend_pbx_r;
            o_pby_nxt    = pend_pby_r;
            pair_go      = 1'b1;
          end
        end else begin
          pair_go = 1'b1;
        end
        if (pair_go) begin
          if (hit_r) begin
            pend_v_nxt = 1'b1;
          end
          if (j_p1 < cnt_r) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_CMP;
          end else if (i_p2 < cnt_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_RD_A;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_end_nxt = 1'b1;
          if (pend_v_r) begin
            o_kind_nxt   = KIND_PAIR;
            o_first_nxt  = pend_a_r;
            o_second_nxt = pend_b_r;
            o_side_nxt   = pend_side_r;
            o_pax_nxt    = pend_pax_r;
            o_pay_nxt    = pend_pay_r;
            o_pbx_nxt    = pend_pbx_r;
            o_pby_nxt    = pend_pby_r;
          end else begin
            o_kind_nxt = KIND_NONE;
          end
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      map_w_r  <= MAP_RESET;
      map_h_r  <= MAP_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we && cfg_index == CFG_MAP_WIDTH) begin
        map_w_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_MAP_HEIGHT) begin
        map_h_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (state_r == ST_LD_A) begin
      ax_r  <= rd_x;
      ay_r  <= rd_y;
      aw_r  <= rd_w;
      ah_r  <= rd_h;
      axe_r <= edge_end(rd_x, rd_w);
      aye_r <= edge_end(rd_y, rd_h);
    end
    if (state_r == ST_CMP) begin
      bx_r  <= rd_x;
      by_r  <= rd_y;
      bw_r  <= rd_w;
      bh_r  <= rd_h;
      bxe_r <= edge_end(rd_x, rd_w);
      bye_r <= edge_end(rd_y, rd_h);
    end
    if (state_r == ST_ISECT) begin
      hit_r   <= (aw_r != '0) && (ah_r != '0) && (bw_r != '0) && (bh_r != '0) &&
                 !iwf[EW] && (iwf != '0) && !ihf[EW] && (ihf != '0);
      left_r  <= ax_r >= bx_r;
      right_r <= axe_r <= bxe_r;
      above_r <= ay_r >= by_r;
      below_r <= aye_r <= bye_r;
      iw_r    <= iwf[SIZE_BITS-1:0];
      ih_r    <= ihf[SIZE_BITS-1:0];
    end
    if (state_r == ST_EMIT && pair_go && hit_r) begin
      pend_a_r    <= IDX_BITS'(i_r);
      pend_b_r    <= IDX_BITS'(j_r);
      pend_side_r <= new_side;
      pend_pax_r  <= new_pax;
      pend_pay_r  <= new_pay;
      pend_pbx_r  <= new_pbx;
      pend_pby_r  <= new_pby;
    end
    if (out_load) begin
      o_kind_r   <= o_kind_nxt;
      o_first_r  <= o_first_nxt;
      o_second_r <= o_second_nxt;
      o_cx_r     <= o_cx_nxt;
      o_cy_r     <= o_cy_nxt;
      o_side_r   <= o_side_nxt;
      o_pax_r    <= o_pax_nxt;
      o_pay_r    <= o_pay_nxt;
      o_pbx_r    <= o_pbx_nxt;
      o_pby_r    <= o_pby_nxt;
      o_end_r    <= o_end_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_kind  = o_kind_r;
  assign out_ch.first_index  = o_first_r;
  assign out_ch.second_index = o_second_r;
  assign out_ch.clamped_x    = o_cx_r;
  assign out_ch.clamped_y    = o_cy_r;
  assign out_ch.contact_side = o_side_r;
  assign out_ch.push_a_x     = o_pax_r;
  assign out_ch.push_a_y     = o_pay_r;
  assign out_ch.push_b_x     = o_pbx_r;
  assign out_ch.push_b_y     = o_pby_r;
  assign out_ch.run_end      = o_end_r;

endmodule
